### hdl/assert_macros.svh
// assertion macros shared by the conversion block modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent check on clk, off while rst_n is low
`define AAQ_ASSERT(name, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// condition that must never be seen
`define AAQ_NEVER(name, cond, msg) \
    `AAQ_ASSERT(name, !(cond), msg)

`endif

### hdl/aaq_pkg.sv
// shared types and constants of the axis-angle to quaternion block
package aaq_pkg;

    localparam int COMP_BITS        = 16;
    localparam int ANGLE_FIELD_BITS = 18;
    localparam int ANGLE_BITS       = 17;
    localparam int REM_BITS         = ANGLE_BITS - 2;
    localparam int FRAC_BITS        = COMP_BITS - 1;

    localparam int Q_FRAC  = 30;
    localparam int T_BITS  = 31;
    localparam int T2_BITS = 32;
    localparam int S_BITS  = 31;

    localparam logic [T_BITS-1:0] HALF_PI_Q30 = 31'd1686629713;
    localparam logic [S_BITS-1:0] Q30_ONE     = 31'h4000_0000;

    localparam int TERMS      = 7;
    localparam int SINCOS_LAT = 2 * TERMS + 2;

    localparam int QUEUE_DEPTH = 4;

    localparam int IN_TDATA_BITS  = ((3 * COMP_BITS + ANGLE_FIELD_BITS + 7) / 8) * 8;
    localparam int OUT_TDATA_BITS = ((4 * COMP_BITS + 7) / 8) * 8;

    typedef logic signed [COMP_BITS-1:0] comp_t;

    typedef enum logic [1:0] {
        QUAD_0,
        QUAD_1,
        QUAD_2,
        QUAD_3
    } quad_t;

    typedef struct packed {
        comp_t              axis_x;
        comp_t              axis_y;
        comp_t              axis_z;
        quad_t              quad;
        logic [T_BITS-1:0]  t;
    } item_t;

endpackage

### hdl/axis_angle_to_quaternion_top.sv
// top level of the axis-angle to quaternion converter
//
//  channel  dir  width  contents
//  s_axis   in   72     axis_x, axis_y, axis_z (q1.15), angle (18 bit signed)
//  m_axis   out  64     quat_x, quat_y, quat_z, quat_w (q1.15)
//
// one beat per cycle sustained while m_axis_tready stays high
// latency is set by the sine/cosine series pipeline: two stages for each of seven terms
// front register and a four-entry queue let s_axis keep flowing while m_axis stalls
// m_axis_tready low while m_axis_tvalid is high freezes the whole back pipeline; s_axis_tready drops once queue fills
// reset clears only valid bits and queue pointers, no clearing pass
module axis_angle_to_quaternion_top #(
    parameter int QUEUE_DEPTH = aaq_pkg::QUEUE_DEPTH
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   s_axis_tvalid,
    output logic                                   s_axis_tready,
    // axis_x, axis_y, axis_z, angle, zero pad
    input  logic [aaq_pkg::IN_TDATA_BITS-1:0]      s_axis_tdata,
    output logic                                   m_axis_tvalid,
    input  logic                                   m_axis_tready,
    // quat_x, quat_y, quat_z, quat_w
    output logic [aaq_pkg::OUT_TDATA_BITS-1:0]     m_axis_tdata
);

    localparam int CW = aaq_pkg::COMP_BITS;

    aaq_pkg::comp_t                         axis_x;
    aaq_pkg::comp_t                         axis_y;
    aaq_pkg::comp_t                         axis_z;
    logic [aaq_pkg::ANGLE_FIELD_BITS-1:0]   angle;
    logic                                   enq;
    logic                                   enq_ready;
    aaq_pkg::item_t                         enq_item;
    logic                                   deq_valid;
    logic                                   deq;
    aaq_pkg::item_t                         deq_item;
    aaq_pkg::comp_t                         quat_x;
    aaq_pkg::comp_t                         quat_y;
    aaq_pkg::comp_t                         quat_z;
    aaq_pkg::comp_t                         quat_w;

    assign axis_x = s_axis_tdata[0 +: CW];
    assign axis_y = s_axis_tdata[CW +: CW];
    assign axis_z = s_axis_tdata[2*CW +: CW];
    assign angle  = s_axis_tdata[3*CW +: aaq_pkg::ANGLE_FIELD_BITS];

    aaq_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .axis_x    (axis_x),
        .axis_y    (axis_y),
        .axis_z    (axis_z),
        .angle     (angle),
        .enq       (enq),
        .enq_ready (enq_ready),
        .enq_item  (enq_item)
    );

    aaq_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (enq),
        .push_ready (enq_ready),
        .push_item  (enq_item),
        .pop_valid  (deq_valid),
        .pop        (deq),
        .pop_item   (deq_item)
    );

    aaq_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .deq_valid (deq_valid),
        .deq_item  (deq_item),
        .deq       (deq),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .quat_x    (quat_x),
        .quat_y    (quat_y),
        .quat_z    (quat_z),
        .quat_w    (quat_w)
    );

    assign m_axis_tdata = {quat_w, quat_z, quat_y, quat_x};

endmodule

### hdl/aaq_front.sv
// input stage: splits the angle into quadrant and first-quadrant angle
`include "assert_macros.svh"

module aaq_front (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  aaq_pkg::comp_t                         axis_x,
    input  aaq_pkg::comp_t                         axis_y,
    input  aaq_pkg::comp_t                         axis_z,
    input  logic [aaq_pkg::ANGLE_FIELD_BITS-1:0]   angle,
    output logic                                   enq,
    input  logic                                   enq_ready,
    output aaq_pkg::item_t                         enq_item
);

    localparam int PW = aaq_pkg::REM_BITS + aaq_pkg::T_BITS;

    logic                               valid_reg;
    logic                               valid_next;
    aaq_pkg::item_t                     item_reg;
    aaq_pkg::item_t                     item_next;
    logic [aaq_pkg::ANGLE_BITS-1:0]     phase;
    logic [aaq_pkg::REM_BITS-1:0]       rem;
    logic [PW-1:0]                      t_prod;

    assign phase  = angle[aaq_pkg::ANGLE_BITS-1:0];
    assign rem    = phase[aaq_pkg::REM_BITS-1:0];
    // rem * pi/2 in q30, rounded to nearest
    assign t_prod = PW'(rem) * PW'(aaq_pkg::HALF_PI_Q30)
                  + (PW'(1) << (aaq_pkg::REM_BITS - 1));

    always_comb
    begin
        item_next.axis_x = axis_x;
        item_next.axis_y = axis_y;
        item_next.axis_z = axis_z;
        item_next.quad   = aaq_pkg::quad_t'(phase[aaq_pkg::ANGLE_BITS-1 -: 2]);
        item_next.t      = t_prod[aaq_pkg::REM_BITS +: aaq_pkg::T_BITS];
    end

    assign in_ready   = !valid_reg || enq_ready;
    assign enq        = valid_reg && enq_ready;
    assign enq_item   = item_reg;
    assign valid_next = in_ready ? in_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= item_next;
        end
    end

    `AAQ_ASSERT(a_front_hold, (valid_reg && !enq_ready) |=> (valid_reg && $stable(item_reg)), "front item lost while queue full")

endmodule

### hdl/aaq_queue.sv
// short fifo between the front and the back pipeline
`include "assert_macros.svh"

module aaq_queue #(
    parameter int DEPTH = aaq_pkg::QUEUE_DEPTH
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    output logic           push_ready,
    input  aaq_pkg::item_t push_item,
    output logic           pop_valid,
    input  logic           pop,
    output aaq_pkg::item_t pop_item
);

    localparam int PTR_BITS = $clog2(DEPTH);
    localparam int CNT_BITS = $clog2(DEPTH + 1);
    localparam logic [PTR_BITS-1:0] LAST_PTR   = PTR_BITS'(DEPTH - 1);
    localparam logic [CNT_BITS-1:0] FULL_COUNT = CNT_BITS'(DEPTH);

    aaq_pkg::item_t         entries_reg [DEPTH];
    logic [PTR_BITS-1:0]    wr_ptr_reg;
    logic [PTR_BITS-1:0]    wr_ptr_next;
    logic [PTR_BITS-1:0]    rd_ptr_reg;
    logic [PTR_BITS-1:0]    rd_ptr_next;
    logic [CNT_BITS-1:0]    count_reg;
    logic [CNT_BITS-1:0]    count_next;

    assign push_ready = (count_reg != FULL_COUNT);
    assign pop_valid  = (count_reg != '0);
    assign pop_item   = entries_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PTR_BITS'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PTR_BITS'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CNT_BITS'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_BITS'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries_reg[wr_ptr_reg] <= push_item;
        end
    end

    `AAQ_NEVER(a_no_overflow, push && (count_reg == FULL_COUNT), "push into full queue")
    `AAQ_NEVER(a_no_underflow, pop && (count_reg == '0), "pop from empty queue")

endmodule

### hdl/aaq_sincos.sv
// pipelined taylor series for sine and cosine of a first-quadrant angle
module aaq_sincos (
    input  logic                         clk,
    input  logic                         en,
    input  logic [aaq_pkg::T_BITS-1:0]   t,
    output logic [aaq_pkg::S_BITS-1:0]   s30,
    output logic [aaq_pkg::S_BITS-1:0]   c30
);

    localparam int NT    = aaq_pkg::TERMS;
    localparam int TW    = aaq_pkg::T_BITS;
    localparam int T2W   = aaq_pkg::T2_BITS;
    localparam int SW    = aaq_pkg::S_BITS;
    localparam int QF    = aaq_pkg::Q_FRAC;
    localparam int DIV_N = T2W;
    localparam int MW    = 2 * DIV_N + 1;

    logic [TW-1:0]      t_reg  [2*NT+1];
    logic [T2W-1:0]     t2_reg [2*NT-1];
    logic [SW-1:0]      s_out  [NT];
    logic [SW-1:0]      c_out  [NT];
    logic [2*TW-1:0]    sq_prod;
    logic [2*TW-1:0]    fin_prod;
    logic [SW-1:0]      s30_reg;
    logic [SW-1:0]      c30_reg;

    assign sq_prod = (2*TW)'(t) * (2*TW)'(t);

    // t and t^2 ride along with the series terms
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            t_reg[0]  <= t;
            t2_reg[0] <= sq_prod[QF +: T2W];
            for (int i = 1; i <= 2 * NT; i++)
            begin
                t_reg[i] <= t_reg[i-1];
            end
            for (int i = 1; i < 2 * NT - 1; i++)
            begin
                t2_reg[i] <= t2_reg[i-1];
            end
        end
    end

    // one term per two stages: product with t^2, then exact divide by reciprocal
    for (genvar j = 0; j < NT; j++)
    begin : g_term
        localparam int K     = NT - j;
        localparam int S_DIV = (2 * K) * (2 * K + 1);
        localparam int C_DIV = (2 * K - 1) * (2 * K);
        localparam int S_SH  = DIV_N + $clog2(S_DIV);
        localparam int C_SH  = DIV_N + $clog2(C_DIV);
        localparam logic [DIV_N:0] S_MAGIC =
            (DIV_N+1)'(((MW'(1) << S_SH) + MW'(S_DIV - 1)) / MW'(S_DIV));
        localparam logic [DIV_N:0] C_MAGIC =
            (DIV_N+1)'(((MW'(1) << C_SH) + MW'(C_DIV - 1)) / MW'(C_DIV));

        logic [SW-1:0]      s_in;
        logic [SW-1:0]      c_in;
        logic [T2W+SW-1:0]  s_mul;
        logic [T2W+SW-1:0]  c_mul;
        logic [T2W-1:0]     ps_reg;
        logic [T2W-1:0]     pc_reg;
        logic [MW-1:0]      s_quo;
        logic [MW-1:0]      c_quo;
        logic [SW-1:0]      s_reg;
        logic [SW-1:0]      c_reg;

        if (j == 0)
        begin : g_first
            assign s_in = aaq_pkg::Q30_ONE;
            assign c_in = aaq_pkg::Q30_ONE;
        end
        else
        begin : g_next
            assign s_in = s_out[j-1];
            assign c_in = c_out[j-1];
        end

        assign s_mul = (T2W+SW)'(t2_reg[2*j]) * (T2W+SW)'(s_in);
        assign c_mul = (T2W+SW)'(t2_reg[2*j]) * (T2W+SW)'(c_in);
        assign s_quo = (MW'(ps_reg) * MW'(S_MAGIC)) >> S_SH;
        assign c_quo = (MW'(pc_reg) * MW'(C_MAGIC)) >> C_SH;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                ps_reg <= s_mul[QF +: T2W];
                pc_reg <= c_mul[QF +: T2W];
                s_reg  <= aaq_pkg::Q30_ONE - s_quo[SW-1:0];
                // cosine step clamps at zero
                if (c_quo[T2W-1:0] > T2W'(aaq_pkg::Q30_ONE))
                begin
                    c_reg <= '0;
                end
                else
                begin
                    c_reg <= aaq_pkg::Q30_ONE - c_quo[SW-1:0];
                end
            end
        end

        assign s_out[j] = s_reg;
        assign c_out[j] = c_reg;
    end

    assign fin_prod = (2*TW)'(t_reg[2*NT]) * (2*TW)'(s_out[NT-1]);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s30_reg <= fin_prod[QF +: SW];
            c30_reg <= c_out[NT-1];
        end
    end

    assign s30 = s30_reg;
    assign c30 = c30_reg;

endmodule

### hdl/aaq_back.sv
// back pipeline: sine/cosine, quadrant fold, scaling and output register
`include "assert_macros.svh"

module aaq_back (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           deq_valid,
    input  aaq_pkg::item_t deq_item,
    output logic           deq,
    output logic           out_valid,
    input  logic           out_ready,
    output aaq_pkg::comp_t quat_x,
    output aaq_pkg::comp_t quat_y,
    output aaq_pkg::comp_t quat_z,
    output aaq_pkg::comp_t quat_w
);

    localparam int LAT      = aaq_pkg::SINCOS_LAT;
    localparam int PIPE_LEN = LAT + 3;
    localparam int CW       = aaq_pkg::COMP_BITS;
    localparam int FB       = aaq_pkg::FRAC_BITS;
    localparam int SW       = aaq_pkg::S_BITS;
    localparam int RSH      = aaq_pkg::Q_FRAC - FB;
    localparam int PROD_W   = 2 * CW;

    localparam logic [SW:0]               TRIG_RND = (SW+1)'(1) << (RSH - 1);
    localparam logic [SW:0]               TRIG_MAX = (SW+1)'((1 << FB) - 1);
    localparam logic signed [PROD_W:0]    MUL_RND  = (PROD_W+1)'(1) << (FB - 1);
    localparam logic signed [PROD_W:0]    SAT_HI   = (PROD_W+1)'((1 << FB) - 1);
    localparam logic signed [PROD_W:0]    SAT_LO   = ~SAT_HI;
    localparam aaq_pkg::comp_t            COMP_MAX = CW'((1 << FB) - 1);
    localparam aaq_pkg::comp_t            COMP_MIN = ~COMP_MAX;

    typedef struct packed {
        aaq_pkg::comp_t axis_x;
        aaq_pkg::comp_t axis_y;
        aaq_pkg::comp_t axis_z;
        aaq_pkg::quad_t quad;
    } side_t;

    logic                           adv;
    logic [PIPE_LEN-1:0]            vld_reg;
    logic [PIPE_LEN-1:0]            vld_next;
    side_t                          side_reg [LAT];
    logic [SW-1:0]                  s30;
    logic [SW-1:0]                  c30;
    aaq_pkg::comp_t                 s_mag;
    aaq_pkg::comp_t                 c_mag;
    aaq_pkg::comp_t                 sn_next;
    aaq_pkg::comp_t                 cs_next;
    aaq_pkg::comp_t                 sn_reg;
    aaq_pkg::comp_t                 cs_reg;
    aaq_pkg::comp_t                 ax_reg;
    aaq_pkg::comp_t                 ay_reg;
    aaq_pkg::comp_t                 az_reg;
    logic signed [PROD_W-1:0]       px_reg;
    logic signed [PROD_W-1:0]       py_reg;
    logic signed [PROD_W-1:0]       pz_reg;
    aaq_pkg::comp_t                 pw_reg;
    aaq_pkg::comp_t                 quat_x_reg;
    aaq_pkg::comp_t                 quat_y_reg;
    aaq_pkg::comp_t                 quat_z_reg;
    aaq_pkg::comp_t                 quat_w_reg;

    // q30 magnitude to q1.15, ties upward, saturated
    function automatic aaq_pkg::comp_t to_comp(input logic [SW-1:0] v);
        logic [SW:0] sum;
        logic [SW:0] q;
        sum = {1'b0, v} + TRIG_RND;
        q   = sum >> RSH;
        if (q > TRIG_MAX)
        begin
            to_comp = COMP_MAX;
        end
        else
        begin
            to_comp = aaq_pkg::comp_t'(q[CW-1:0]);
        end
    endfunction

    // product back to q1.15, ties toward plus infinity, saturated
    function automatic aaq_pkg::comp_t round_sat(input logic signed [PROD_W-1:0] p);
        logic signed [PROD_W:0] sum;
        logic signed [PROD_W:0] q;
        sum = (PROD_W+1)'(p) + MUL_RND;
        q   = sum >>> FB;
        if (q > SAT_HI)
        begin
            round_sat = COMP_MAX;
        end
        else if (q < SAT_LO)
        begin
            round_sat = COMP_MIN;
        end
        else
        begin
            round_sat = aaq_pkg::comp_t'(q[CW-1:0]);
        end
    endfunction

    // whole pipe moves when the output register is free or being drained
    assign adv       = !vld_reg[PIPE_LEN-1] || out_ready;
    assign deq       = adv && deq_valid;
    assign vld_next  = {vld_reg[PIPE_LEN-2:0], deq_valid};
    assign out_valid = vld_reg[PIPE_LEN-1];

    aaq_sincos u_sincos (
        .clk (clk),
        .en  (adv),
        .t   (deq_item.t),
        .s30 (s30),
        .c30 (c30)
    );

    assign s_mag = to_comp(s30);
    assign c_mag = to_comp(c30);

    always_comb
    begin
        unique case (side_reg[LAT-1].quad)
            aaq_pkg::QUAD_0:
            begin
                sn_next = s_mag;
                cs_next = c_mag;
            end
            aaq_pkg::QUAD_1:
            begin
                sn_next = c_mag;
                cs_next = -s_mag;
            end
            aaq_pkg::QUAD_2:
            begin
                sn_next = -s_mag;
                cs_next = -c_mag;
            end
            aaq_pkg::QUAD_3:
            begin
                sn_next = -c_mag;
                cs_next = s_mag;
            end
            default:
            begin
                sn_next = s_mag;
                cs_next = c_mag;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            side_reg[0].axis_x <= deq_item.axis_x;
            side_reg[0].axis_y <= deq_item.axis_y;
            side_reg[0].axis_z <= deq_item.axis_z;
            side_reg[0].quad   <= deq_item.quad;
            for (int i = 1; i < LAT; i++)
            begin
                side_reg[i] <= side_reg[i-1];
            end

            sn_reg <= sn_next;
            cs_reg <= cs_next;
            ax_reg <= side_reg[LAT-1].axis_x;
            ay_reg <= side_reg[LAT-1].axis_y;
            az_reg <= side_reg[LAT-1].axis_z;

            px_reg <= PROD_W'(ax_reg) * PROD_W'(sn_reg);
            py_reg <= PROD_W'(ay_reg) * PROD_W'(sn_reg);
            pz_reg <= PROD_W'(az_reg) * PROD_W'(sn_reg);
            pw_reg <= cs_reg;

            quat_x_reg <= round_sat(px_reg);
            quat_y_reg <= round_sat(py_reg);
            quat_z_reg <= round_sat(pz_reg);
            quat_w_reg <= pw_reg;
        end
    end

    assign quat_x = quat_x_reg;
    assign quat_y = quat_y_reg;
    assign quat_z = quat_z_reg;
    assign quat_w = quat_w_reg;

    `AAQ_NEVER(a_no_pop_on_stall, out_valid && !out_ready && deq, "queue popped while output stalled")
    `AAQ_ASSERT(a_out_from_pipe, $rose(out_valid) |-> $past(vld_reg[PIPE_LEN-2]), "result appeared without an item in flight")

endmodule

### dv/axis_angle_to_quaternion_top_tb.sv
// testbench of the axis-angle to quaternion converter: directed and random beats, self-checking
`timescale 1ns / 1ps

module axis_angle_to_quaternion_top_tb;

    localparam longint unsigned UNIT_Q30    = 64'd1 << 30;
    localparam longint unsigned QTR_TURN_Q30 = 64'd1686629713;
    localparam int              TIMEOUT_CYCLES = 300000;

    typedef logic signed [aaq_pkg::ANGLE_FIELD_BITS-1:0] angle_t;

    typedef struct {
        aaq_pkg::comp_t x;
        aaq_pkg::comp_t y;
        aaq_pkg::comp_t z;
        aaq_pkg::comp_t w;
    } quat_val_t;

    logic                                 clk;
    logic                                 rst_n;
    logic                                 s_axis_tvalid;
    logic                                 s_axis_tready;
    logic [aaq_pkg::IN_TDATA_BITS-1:0]    s_axis_tdata;
    logic                                 m_axis_tvalid;
    logic                                 m_axis_tready;
    logic [aaq_pkg::OUT_TDATA_BITS-1:0]   m_axis_tdata;

    quat_val_t pending_quats[$];
    int        beats_sent;
    int        quats_checked;
    int        mismatch_count;
    int        stray_count;
    bit        idle_en;
    int        hold_req;

    axis_angle_to_quaternion_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #(TIMEOUT_CYCLES * 12);
        $display("timeout: %0d quaternions still pending", pending_quats.size());
        $display("Some tests failed");
        $finish;
    end

    // truncating taylor series of sin and cos on [0, pi/2), all in q30
    function automatic void series_sin_cos(input longint unsigned t,
                                           output longint unsigned sin_q30,
                                           output longint unsigned cos_q30);
        longint unsigned t_sq;
        longint unsigned s_acc;
        longint unsigned c_acc;
        longint unsigned c_drop;
        longint unsigned k;
        t_sq  = (t * t) >> 30;
        s_acc = UNIT_Q30;
        c_acc = UNIT_Q30;
        for (k = 7; k >= 1; k--)
        begin
            s_acc  = UNIT_Q30 - ((t_sq * s_acc) >> 30) / ((2 * k) * (2 * k + 1));
            c_drop = ((t_sq * c_acc) >> 30) / ((2 * k - 1) * (2 * k));
            c_acc  = (c_drop > UNIT_Q30) ? 64'd0 : UNIT_Q30 - c_drop;
        end
        sin_q30 = (t * s_acc) >> 30;
        cos_q30 = c_acc;
    endfunction

    function automatic aaq_pkg::comp_t q30_to_q15(input longint unsigned v);
        longint unsigned r;
        r = (v + (64'd1 << 14)) >> 15;
        if (r > 64'd32767)
            r = 64'd32767;
        return aaq_pkg::comp_t'(r[15:0]);
    endfunction

    // q1.15 product, halfway rounds up, saturated
    function automatic aaq_pkg::comp_t scale_q15(input aaq_pkg::comp_t a,
                                                 input aaq_pkg::comp_t b);
        longint p;
        p = longint'(a) * longint'(b);
        p = (p + 64'sd16384) >>> 15;
        if (p > 32767)
            p = 32767;
        else if (p < -32768)
            p = -32768;
        return aaq_pkg::comp_t'(p[15:0]);
    endfunction

    function automatic quat_val_t quat_from_axis_angle(input aaq_pkg::comp_t ax,
                                                        input aaq_pkg::comp_t ay,
                                                        input aaq_pkg::comp_t az,
                                                        input angle_t ang);
        quat_val_t       q;
        logic [16:0]     phase;
        aaq_pkg::quad_t  quad;
        longint unsigned t;
        longint unsigned sin_q30;
        longint unsigned cos_q30;
        aaq_pkg::comp_t  s;
        aaq_pkg::comp_t  c;
        aaq_pkg::comp_t  sn;
        phase = ang[16:0];
        quad  = aaq_pkg::quad_t'(phase[16:15]);
        t = (64'(phase[14:0]) * QTR_TURN_Q30 + (64'd1 << 14)) >> 15;
        series_sin_cos(t, sin_q30, cos_q30);
        s = q30_to_q15(sin_q30);
        c = q30_to_q15(cos_q30);
        case (quad)
            aaq_pkg::QUAD_0:
            begin
                sn  = s;
                q.w = c;
            end
            aaq_pkg::QUAD_1:
            begin
                sn  = c;
                q.w = -s;
            end
            aaq_pkg::QUAD_2:
            begin
                sn  = -s;
                q.w = -c;
            end
            default:
            begin
                sn  = -c;
                q.w = s;
            end
        endcase
        q.x = scale_q15(ax, sn);
        q.y = scale_q15(ay, sn);
        q.z = scale_q15(az, sn);
        return q;
    endfunction

    // called at a falling edge, returns at a falling edge after the beat is taken
    task automatic send_beat(input aaq_pkg::comp_t ax, input aaq_pkg::comp_t ay,
                             input aaq_pkg::comp_t az, input angle_t ang);
        int gap;
        if (idle_en && $urandom_range(0, 7) == 0)
        begin
            gap = $urandom_range(1, 4);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(aaq_pkg::IN_TDATA_BITS - 3 * aaq_pkg::COMP_BITS
                            - aaq_pkg::ANGLE_FIELD_BITS){1'b0}},
                          ang, az, ay, ax};
        do
            @(posedge clk);
        while (!s_axis_tready);
        pending_quats.push_back(quat_from_axis_angle(ax, ay, az, ang));
        beats_sent++;
        @(negedge clk);
    endtask

    function automatic aaq_pkg::comp_t rand_comp();
        case ($urandom_range(0, 7))
            0:       return aaq_pkg::comp_t'(16'h8000);
            1:       return aaq_pkg::comp_t'(16'h7fff);
            2:       return aaq_pkg::comp_t'($urandom_range(0, 8) - 4);
            default: return aaq_pkg::comp_t'($urandom);
        endcase
    endfunction

    // about a third of the angles land right around a quadrant edge
    function automatic angle_t rand_angle();
        if ($urandom_range(0, 2) == 0)
            return angle_t'($urandom_range(0, 7) * 32768 + $urandom_range(0, 8) - 4);
        return angle_t'($urandom);
    endfunction

    task automatic test_field_extremes();
        send_beat(16'sd32767, 16'sd32767, 16'sd32767, 18'sd0);
        send_beat(-16'sd32768, -16'sd32768, -16'sd32768, 18'sd131071);
        send_beat(16'sd32767, -16'sd32768, 16'sd0, -18'sd131072);
        send_beat(16'sd1, -16'sd1, 16'sd0, 18'sd32768);
        send_beat(-16'sd1, 16'sd1, 16'sd32767, 18'sd65536);
        send_beat(-16'sd32768, 16'sd32767, 16'sd1, 18'sd98304);
        // half-scale axis against odd sines gives exact halfway products
        send_beat(16'sd16384, -16'sd16384, 16'sd16385, 18'sd16384);
        send_beat(16'sd16384, -16'sd16384, -16'sd16385, 18'sd40000);
        // most negative axis times a negative sine
        send_beat(-16'sd32768, -16'sd32768, 16'sd32767, 18'sd98305);
        send_beat(-16'sd32768, 16'sd0, 16'sd0, 18'sd70000);
    endtask

    task automatic test_special_angles();
        angle_t base_angles[3];
        int i;
        base_angles = '{18'sd5000, 18'sd70000, 18'sd131000};
        // same phase with and without the top bit of the angle field
        for (i = 0; i < 3; i++)
        begin
            send_beat(16'sd12000, -16'sd20000, 16'sd30000, base_angles[i]);
            send_beat(16'sd12000, -16'sd20000, 16'sd30000, base_angles[i] - 18'sd131072);
        end
        send_beat(16'sd23170, 16'sd23170, 16'sd0, 18'sd32767);
        send_beat(16'sd23170, 16'sd23170, 16'sd0, 18'sd65535);
        send_beat(16'sd23170, 16'sd23170, 16'sd0, 18'sd98303);
    endtask

    task automatic test_random_stream(input int n);
        int i;
        for (i = 0; i < n; i++)
            send_beat(rand_comp(), rand_comp(), rand_comp(), rand_angle());
    endtask

    task automatic test_input_stall();
        int i;
        hold_req = 200;
        for (i = 0; i < 48; i++)
            send_beat(rand_comp(), rand_comp(), rand_comp(), rand_angle());
    endtask

    task automatic test_full_rate();
        idle_en = 1'b0;
        test_random_stream(330);
    endtask

    // m_axis ready: short random stalls plus an occasional long hold-off
    initial
    begin
        int stall_left;
        int hold_left;
        stall_left    = 0;
        hold_left     = 0;
        m_axis_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req > 0)
            begin
                hold_left = hold_req;
                hold_req  = 0;
            end
            if (hold_left > 0)
                hold_left--;
            else if (stall_left > 0)
                stall_left--;
            else if (idle_en && rst_n && $urandom_range(0, 9) == 0)
                stall_left = $urandom_range(1, 4) - 1;
            m_axis_tready <= rst_n && hold_left == 0 && stall_left == 0 &&
                             !(idle_en && $urandom_range(0, 9) == 0);
        end
    end

    initial
    begin
        quat_val_t expected;
        quat_val_t actual;
        forever
        begin
            @(posedge clk);
            if (rst_n && m_axis_tvalid && m_axis_tready)
            begin
                actual.x = m_axis_tdata[15:0];
                actual.y = m_axis_tdata[31:16];
                actual.z = m_axis_tdata[47:32];
                actual.w = m_axis_tdata[63:48];
                if (pending_quats.size() == 0)
                begin
                    stray_count++;
                    $display("unexpected beat on m_axis: %h", m_axis_tdata);
                end
                else
                begin
                    expected = pending_quats.pop_front();
                    quats_checked++;
                    if (actual.x !== expected.x || actual.y !== expected.y ||
                        actual.z !== expected.z || actual.w !== expected.w)
                    begin
                        if (mismatch_count < 10)
                            $display({"mismatch on beat %0d: exp x=%0d y=%0d z=%0d w=%0d,",
                                      " got x=%0d y=%0d z=%0d w=%0d"},
                                     quats_checked, expected.x, expected.y, expected.z,
                                     expected.w, actual.x, actual.y, actual.z, actual.w);
                        mismatch_count++;
                    end
                end
            end
        end
    end

    initial
    begin
        rst_n          = 1'b0;
        s_axis_tvalid  = 1'b0;
        s_axis_tdata   = '0;
        idle_en        = 1'b1;
        hold_req       = 0;
        beats_sent     = 0;
        quats_checked  = 0;
        mismatch_count = 0;
        stray_count    = 0;
        repeat (5) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_field_extremes();
        test_special_angles();
        test_random_stream(1000);
        test_input_stall();
        test_full_rate();
        s_axis_tvalid <= 1'b0;

        while (pending_quats.size() != 0)
            @(posedge clk);
        repeat (aaq_pkg::SINCOS_LAT + aaq_pkg::QUEUE_DEPTH + 16) @(posedge clk);

        $display("%0d beats in, %0d quaternions checked, %0d mismatches, %0d unexpected",
                 beats_sent, quats_checked, mismatch_count, stray_count);
        $display("covered field extremes, all quadrants, angle wrap, halfway rounding, stalls");
        if (mismatch_count == 0 && stray_count == 0 && pending_quats.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
